>>> hw/rtl/ibpf_pkg.sv
package ibpf_pkg;

    localparam int PITCH_W  = 13;
    localparam int BPP_W    = 3;
    localparam int SMODE_W  = 4;
    localparam int IMODE_W  = 2;

    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_PITCH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BYTES_PER_PX = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPATIAL_MODE = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_INTER_MODE   = 2'd3;

    typedef enum logic [SMODE_W-1:0] {
        SP_RAW       = 4'd0,
        SP_LEFT_XOR  = 4'd1,
        SP_LEFT_SUB  = 4'd2,
        SP_UP_XOR    = 4'd3,
        SP_UP_SUB    = 4'd4,
        SP_AVG_XOR   = 4'd5,
        SP_AVG_SUB   = 4'd6,
        SP_PAETH_XOR = 4'd7,
        SP_PAETH_SUB = 4'd8
    } sp_mode_t;

    typedef enum logic [IMODE_W-1:0] {
        INTER_NONE = 2'd0,
        INTER_XOR  = 2'd1,
        INTER_SUB  = 2'd2
    } inter_mode_t;

    // neighborhood of one byte, all values after the inter-image stage
    typedef struct packed {
        logic [7:0] v;
        logic [7:0] lin_left;
        logic [7:0] row_left;
        logic [7:0] up;
        logic [7:0] upleft;
    } ibpf_nbr_t;

endpackage

>>> hw/rtl/ibpf_predict.sv
module ibpf_predict (
    input  ibpf_pkg::ibpf_nbr_t          nbr,
    input  logic [ibpf_pkg::SMODE_W-1:0] spatial_mode,
    output logic [7:0]                   filtered_byte
);
    import ibpf_pkg::*;

    logic [8:0]        avg_sum;
    logic signed [9:0] sa;
    logic signed [9:0] sb;
    logic signed [9:0] sc;
    logic signed [9:0] d_a;
    logic signed [9:0] d_b;
    logic signed [9:0] d_c;
    logic [9:0]        pa;
    logic [9:0]        pb;
    logic [9:0]        pc;
    logic [7:0]        paeth;
    logic [7:0]        pred;
    logic              use_sub;

    assign avg_sum = {1'b0, nbr.row_left} + {1'b0, nbr.up};

    // paeth: a = left, b = up, c = up-left, distances measured from a + b - c
    assign sa  = $signed({2'b00, nbr.row_left});
    assign sb  = $signed({2'b00, nbr.up});
    assign sc  = $signed({2'b00, nbr.upleft});
    assign d_a = sb - sc;
    assign d_b = sa - sc;
    assign d_c = sa + sb - sc - sc;
    assign pa  = d_a[9] ? 10'(-d_a) : 10'(d_a);
    assign pb  = d_b[9] ? 10'(-d_b) : 10'(d_b);
    assign pc  = d_c[9] ? 10'(-d_c) : 10'(d_c);

    always_comb begin
        if (pa <= pb && pa <= pc) begin
            paeth = nbr.row_left;
        end else if (pb <= pc) begin
            paeth = nbr.up;
        end else begin
            paeth = nbr.upleft;
        end
    end

    always_comb begin
        pred    = 8'd0;
        use_sub = 1'b0;
        case (spatial_mode)
            SP_LEFT_XOR:  pred = nbr.lin_left;
            SP_LEFT_SUB: begin
                pred    = nbr.lin_left;
                use_sub = 1'b1;
            end
            SP_UP_XOR:    pred = nbr.up;
            SP_UP_SUB: begin
                pred    = nbr.up;
                use_sub = 1'b1;
            end
            SP_AVG_XOR:   pred = avg_sum[8:1];
            SP_AVG_SUB: begin
                pred    = avg_sum[8:1];
                use_sub = 1'b1;
            end
            SP_PAETH_XOR: pred = paeth;
            SP_PAETH_SUB: begin
                pred    = paeth;
                use_sub = 1'b1;
            end
            default: begin
                pred    = 8'd0;
                use_sub = 1'b0;
            end
        endcase
    end

    assign filtered_byte = use_sub ? (nbr.v - pred) : (nbr.v ^ pred);

endmodule

>>> hw/rtl/image_byte_predictor_filter_top.sv
// Image byte prediction filter: every input beat carries one image byte and the byte at the
// same place in a parent image, and yields exactly one residual byte. One byte is taken
// every clock cycle with no bubbles while m_tready holds; a result passes through the input
// stage, then the output register. The input stage exists because the previous-row line
// store is a single memory that is read and written at the same column on the input beat,
// with its read data registered. The line store has no clearing pass: the up neighbor is
// used only from the second row of an image on, and that entry was written one row earlier.
module image_byte_predictor_filter_top #(
    parameter int LINE_BYTES = 4096,
    parameter int MAX_BPP    = 4
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,   // pixel_byte, parent_byte
    input  logic                             s_tlast,
    input  logic [0:0]                       s_tuser,   // first_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // filtered_byte
    output logic                             m_tlast,
    input  logic                             cfg_we,
    input  logic [ibpf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ibpf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ibpf_pkg::*;

    localparam int CW  = $clog2(LINE_BYTES);
    localparam int HIW = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;
    localparam int SCW = $clog2(MAX_BPP + 1);
    localparam int PCW = (CW + 1 > PITCH_W) ? CW + 1 : PITCH_W;

    // configuration
    logic [PITCH_W-1:0] pitch_reg;
    logic [BPP_W-1:0]   bpp_reg;
    logic [SMODE_W-1:0] smode_reg;
    logic [IMODE_W-1:0] imode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_reg <= PITCH_W'(1);
            bpp_reg   <= BPP_W'(1);
            smode_reg <= SP_RAW;
            imode_reg <= INTER_NONE;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ROW_PITCH:    pitch_reg <= cfg_data[PITCH_W-1:0];
                CFG_BYTES_PER_PX: bpp_reg   <= cfg_data[BPP_W-1:0];
                CFG_SPATIAL_MODE: smode_reg <= cfg_data[SMODE_W-1:0];
                CFG_INTER_MODE:   imode_reg <= cfg_data[IMODE_W-1:0];
                default: ;
            endcase
        end
    end

    logic [PCW-1:0] pitch_eff;
    logic [HIW-1:0] hist_idx;

    always_comb begin
        pitch_eff = PCW'(pitch_reg);
        if (pitch_reg == '0) begin
            pitch_eff = PCW'(1);
        end else if (PCW'(pitch_reg) > PCW'(LINE_BYTES)) begin
            pitch_eff = PCW'(LINE_BYTES);
        end
    end

    // history index is bytes_per_pixel - 1 after clamping
    always_comb begin
        if (bpp_reg == '0) begin
            hist_idx = '0;
        end else if (int'(bpp_reg) > MAX_BPP) begin
            hist_idx = HIW'(MAX_BPP - 1);
        end else begin
            hist_idx = HIW'(bpp_reg - BPP_W'(1));
        end
    end

    // handshake
    logic s1_valid_reg;
    logic s1_valid_next;
    logic m_valid_reg;
    logic m_valid_next;
    logic s_accept;
    logic s1_advance;

    assign s_tready   = !s1_valid_reg || !m_valid_reg || m_tready;
    assign s_accept   = s_tvalid && s_tready;
    assign s1_advance = s1_valid_reg && (!m_valid_reg || m_tready);

    // input side: position, inter stage, left neighbor
    logic [CW-1:0]  col_reg;
    logic [CW-1:0]  col_next;
    logic           pfr_reg;
    logic           pfr_next;
    logic [SCW-1:0] seen_reg;
    logic [SCW-1:0] seen_next;

    logic [7:0]     pix;
    logic [7:0]     par;
    logic           first;
    logic [7:0]     v_in;
    logic [CW-1:0]  col_cur;
    logic           pfr_cur;
    logic [SCW-1:0] seen_cur;
    logic [CW:0]    col_inc;
    logic           wrap;
    logic           have_lin;
    logic           have_row;
    logic [7:0]     left_sel;

    logic [7:0] left_hist_reg [MAX_BPP];
    logic [7:0] upleft_hist_reg [MAX_BPP];
    logic [7:0] line_mem [LINE_BYTES];
    logic [7:0] up_q_reg;

    assign pix   = s_tdata[7:0];
    assign par   = s_tdata[15:8];
    assign first = s_tuser[0];

    always_comb begin
        case (imode_reg)
            INTER_XOR: v_in = pix ^ par;
            INTER_SUB: v_in = pix - par;
            default:   v_in = pix;
        endcase
    end

    assign col_cur  = first ? '0 : col_reg;
    assign pfr_cur  = first ? 1'b0 : pfr_reg;
    assign seen_cur = first ? '0 : seen_reg;
    assign have_lin = 32'(seen_cur) > 32'(hist_idx);
    assign have_row = have_lin && (32'(col_cur) > 32'(hist_idx));
    assign left_sel = left_hist_reg[hist_idx];
    assign col_inc  = {1'b0, col_cur} + (CW + 1)'(1);
    assign wrap     = PCW'(col_inc) >= pitch_eff;

    always_comb begin
        col_next  = wrap ? '0 : col_inc[CW-1:0];
        pfr_next  = wrap ? 1'b1 : pfr_cur;
        seen_next = (seen_cur == SCW'(MAX_BPP)) ? seen_cur : seen_cur + SCW'(1);
        if (s_tlast) begin
            col_next  = '0;
            pfr_next  = 1'b0;
            seen_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            pfr_reg  <= 1'b0;
            seen_reg <= '0;
        end else if (s_accept) begin
            col_reg  <= col_next;
            pfr_reg  <= pfr_next;
            seen_reg <= seen_next;
        end
    end

    // line store: read-first, the beat sees the byte from the row above
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            up_q_reg          <= line_mem[col_cur];
            line_mem[col_cur] <= v_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            for (int i = MAX_BPP - 1; i > 0; i--) begin
                left_hist_reg[i] <= left_hist_reg[i-1];
            end
            left_hist_reg[0] <= v_in;
        end
    end

    // input stage
    logic [7:0] s1_v_reg;
    logic [7:0] s1_lin_left_reg;
    logic [7:0] s1_row_left_reg;
    logic       s1_pfr_reg;
    logic       s1_ul_reg;
    logic       s1_last_reg;

    assign s1_valid_next = s_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_v_reg        <= v_in;
            s1_lin_left_reg <= have_lin ? left_sel : 8'd0;
            s1_row_left_reg <= have_row ? left_sel : 8'd0;
            s1_pfr_reg      <= pfr_cur;
            s1_ul_reg       <= have_row && pfr_cur;
            s1_last_reg     <= s_tlast;
        end
    end

    // up and up-left come from registers, not from the beat itself
    logic [7:0] up_s1;
    logic [7:0] result;
    ibpf_nbr_t  nbr;

    assign up_s1        = s1_pfr_reg ? up_q_reg : 8'd0;
    assign nbr.v        = s1_v_reg;
    assign nbr.lin_left = s1_lin_left_reg;
    assign nbr.row_left = s1_row_left_reg;
    assign nbr.up       = up_s1;
    assign nbr.upleft   = s1_ul_reg ? upleft_hist_reg[hist_idx] : 8'd0;

    ibpf_predict u_predict (
        .nbr           (nbr),
        .spatial_mode  (smode_reg),
        .filtered_byte (result)
    );

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            for (int i = MAX_BPP - 1; i > 0; i--) begin
                upleft_hist_reg[i] <= upleft_hist_reg[i-1];
            end
            upleft_hist_reg[0] <= up_s1;
        end
    end

    // output register
    logic [7:0] m_data_reg;
    logic       m_last_reg;

    always_comb begin
        if (s1_advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            m_data_reg <= result;
            m_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // checks
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !s1_valid_reg |-> s_tready)
        else $error("input not ready while input stage is empty");

    a_restart_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tlast) |=> (col_reg == '0 && !pfr_reg && seen_reg == '0))
        else $error("position not restarted after last beat");

    a_out_from_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s1_valid_reg))
        else $error("result appeared without an item in the input stage");

    a_seen_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg <= SCW'(MAX_BPP))
        else $error("byte count above pixel size limit");

endmodule
